// ===== rtl/mbee_pkg.sv =====
// Package for the masked bit embed/extract block: codes, register indexes
// and the structs passed between the top level and the datapath core.
// No dependencies.
package mbee_pkg;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      CSR_MODE          = 3'd0,
      CSR_BIT_ORDER     = 3'd1,
      CSR_MASK_TABLE    = 3'd2,
      CSR_MASK_COUNT    = 3'd3,
      CSR_SECRET_LENGTH = 3'd4
   } mbee_csr_type;

   typedef enum logic {
      MODE_EMBED   = 1'b0,
      MODE_EXTRACT = 1'b1
   } mbee_mode_type;

   typedef enum logic {
      CMD_CARRIER = 1'b0,
      CMD_LOAD    = 1'b1
   } mbee_cmd_type;

   typedef enum logic [1:0] {
      KIND_CARRIER = 2'd0,
      KIND_SECRET  = 2'd1,
      KIND_LOADED  = 2'd2,
      KIND_NONE    = 2'd3
   } mbee_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_UNDERRUN = 2'd1,
      STATUS_REJECTED = 2'd2
   } mbee_status_type;

   // Configuration seen by the core
   typedef struct packed {
      mbee_mode_type mode;
      logic          bit_order;
      logic [31:0]   secret_length;
   } mbee_cfg_type;

   // Secret bit buffer and progress
   typedef struct packed {
      logic [15:0] store;
      logic [4:0]  fill;
      logic [31:0] bytes_done;
      logic        done;
   } mbee_state_type;

   // One result item
   typedef struct packed {
      logic [7:0]      data_out;
      mbee_kind_type   kind;
      mbee_status_type status;
      logic            finished;
   } mbee_result_type;

endpackage

// ===== rtl/mbee_core.sv =====
// Datapath core: scatters buffered secret bits into a carrier byte or
// gathers selected carrier bits, for one item, in one combinational pass.
// Depends on mbee_pkg.
module mbee_core (
   input  mbee_pkg::mbee_cfg_type    cfg,
   input  mbee_pkg::mbee_state_type  st,
   input  logic [7:0]                mask,
   input  mbee_pkg::mbee_cmd_type    command,
   input  logic [7:0]                data_byte,
   input  logic                      in_range,
   output mbee_pkg::mbee_state_type  st_next,
   output mbee_pkg::mbee_result_type result,
   output logic                      advance
);

   // Put bits into scan order (bit index zero first) or back
   function automatic logic [7:0] order_bits(input logic [7:0] x, input logic rev);
      logic [7:0] y;
      for (int i = 0; i < 8; i++) begin
         y[i] = rev ? x[7 - i] : x[i];
      end
      return y;
   endfunction

   logic [7:0]  data_l;
   logic [7:0]  mask_l;
   logic [2:0]  rank [8];
   logic [3:0]  pop;
   logic [7:0]  gath;
   logic [7:0]  emb_l;
   logic [31:0] bytes_inc;
   logic        hit_len;
   logic [4:0]  avail;
   logic [3:0]  jc;
   logic        emb_complete;
   logic        emb_done;
   logic [3:0]  take;
   logic        under;
   logic [15:0] comb_store;
   logic [4:0]  total;
   logic        ext_complete;
   logic        ext_done;
   logic        load_ok;
   logic [15:0] load_store;

   assign data_l = order_bits(data_byte, cfg.bit_order);
   assign mask_l = order_bits(mask, cfg.bit_order);

   // Rank of each selected position among the selected ones
   always_comb begin
      pop = '0;
      for (int t = 0; t < 8; t++) begin
         rank[t] = pop[2:0];
         pop     = pop + {3'b000, mask_l[t]};
      end
   end

   // Gather selected carrier bits, packed by rank
   always_comb begin
      for (int r = 0; r < 8; r++) begin
         gath[r] = 1'b0;
         for (int t = 0; t < 8; t++) begin
            if (mask_l[t] && (rank[t] == 3'(r))) begin
               gath[r] = data_l[t];
            end
         end
      end
   end

   // Byte count check, shared by both modes
   assign bytes_inc = st.bytes_done + 32'd1;
   assign hit_len   = (bytes_inc >= cfg.secret_length);

   // Embed: bits taken, byte boundary and stop point
   assign avail        = (5'(pop) < st.fill) ? 5'(pop) : st.fill;
   assign jc           = (st.fill[2:0] == 3'd0) ? 4'd8 : {1'b0, st.fill[2:0]};
   assign emb_complete = (st.fill != 5'd0) && (avail >= 5'(jc));
   assign emb_done     = emb_complete && hit_len;
   assign take         = emb_done ? jc : avail[3:0];
   assign under        = (5'(pop) > st.fill) && !emb_done;

   always_comb begin
      for (int t = 0; t < 8; t++) begin
         emb_l[t] = (mask_l[t] && ({1'b0, rank[t]} < take)) ? st.store[rank[t]] : data_l[t];
      end
   end

   // Extract: append gathered bits behind the partial byte
   assign comb_store   = st.store | (16'(gath) << st.fill[2:0]);
   assign total        = st.fill + 5'(pop);
   assign ext_complete = (total >= 5'd8);
   assign ext_done     = ext_complete && hit_len;

   // Secret load into the bit buffer
   assign load_ok    = (st.fill <= 5'd8);
   assign load_store = st.store | (16'(data_l) << st.fill[3:0]);

   // Select the action for this item
   always_comb begin
      st_next         = st;
      result.data_out = 8'h00;
      result.kind     = mbee_pkg::KIND_NONE;
      result.status   = mbee_pkg::STATUS_OK;
      advance         = 1'b0;
      priority if (command == mbee_pkg::CMD_LOAD) begin
         if ((cfg.mode == mbee_pkg::MODE_EMBED) && !st.done) begin
            if (load_ok) begin
               st_next.store = load_store;
               st_next.fill  = st.fill + 5'd8;
               result.kind   = mbee_pkg::KIND_LOADED;
            end else begin
               result.status = mbee_pkg::STATUS_REJECTED;
            end
         end
      end else if (!in_range || st.done) begin
         result.data_out = data_byte;
         result.kind     = mbee_pkg::KIND_CARRIER;
      end else if (cfg.mode == mbee_pkg::MODE_EMBED) begin
         result.data_out = order_bits(emb_l, cfg.bit_order);
         result.kind     = mbee_pkg::KIND_CARRIER;
         result.status   = under ? mbee_pkg::STATUS_UNDERRUN : mbee_pkg::STATUS_OK;
         st_next.store   = st.store >> take;
         st_next.fill    = st.fill - 5'(take);
         if (emb_complete) begin
            st_next.bytes_done = bytes_inc;
         end
         st_next.done = emb_done;
         advance      = 1'b1;
      end else begin
         if (ext_complete) begin
            result.data_out    = order_bits(comb_store[7:0], cfg.bit_order);
            result.kind        = mbee_pkg::KIND_SECRET;
            st_next.bytes_done = bytes_inc;
            if (ext_done) begin
               st_next.store = '0;
               st_next.fill  = '0;
               st_next.done  = 1'b1;
            end else begin
               st_next.store = {8'h00, comb_store[15:8]};
               st_next.fill  = total - 5'd8;
            end
         end else begin
            st_next.store = comb_store;
            st_next.fill  = total;
         end
         advance = 1'b1;
      end
      result.finished = st_next.done;
   end

endmodule

// ===== rtl/masked_bit_embed_extract_top.sv =====
// Top level of the masked bit embed/extract block: configuration registers,
// mask table, input and result registers around mbee_core.
// Depends on mbee_pkg and mbee_core.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser command, tdata byte+range
//   rsp      out        rsp_tvalid/rsp_tready  tuser kind, tdata byte+status+fin
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Every item gives one result item after it is taken, held first in the
// input register and then in the result register. One item per cycle is
// sustained while the result side is not stalled.
// Reset clears the configuration to its defaults and empties the buffer.
// A stalled result holds; the input side keeps taking items until both
// registers are full.
module masked_bit_embed_extract_top #(
   parameter int MASK_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] command
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] in_range, [15:9] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic [15:0] rsp_tdata,   // [7:0] data_out, [9:8] status, [10] finished
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int         POS_W     = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
   localparam logic [3:0] DEPTH_CNT = 4'(MASK_DEPTH);

   mbee_pkg::mbee_mode_type   mode_ff;
   logic                      bit_order_ff;
   logic [7:0]                mask_ff [MASK_DEPTH];
   logic [3:0]                count_ff;
   logic [31:0]               secret_length_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [POS_W-1:0]          pos_in;
   mbee_pkg::mbee_state_type  state_ff;
   mbee_pkg::mbee_state_type  state_in;
   logic                      in_valid_ff;
   mbee_pkg::mbee_cmd_type    in_cmd_ff;
   logic [7:0]                in_data_ff;
   logic                      in_range_ff;
   logic                      rsp_valid_ff;
   mbee_pkg::mbee_result_type rsp_ff;
   mbee_pkg::mbee_result_type result;
   mbee_pkg::mbee_cfg_type    cfg;
   logic                      advance;
   logic                      out_load;
   logic                      step;
   logic                      csr_write;
   logic [3:0]                count_eff;
   logic [3:0]                pos_plus;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= mbee_pkg::MODE_EMBED;
         bit_order_ff     <= 1'b0;
         count_ff         <= 4'd1;
         secret_length_ff <= 32'd1;
         for (int k = 0; k < MASK_DEPTH; k++) begin
            mask_ff[k] <= (k == 0) ? 8'h01 : 8'h00;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            mbee_pkg::CSR_MODE: begin
               mode_ff <= mbee_pkg::mbee_mode_type'(csr_data[0]);
            end
            mbee_pkg::CSR_BIT_ORDER: begin
               bit_order_ff <= csr_data[0];
            end
            mbee_pkg::CSR_MASK_TABLE: begin
               for (int k = 0; k < MASK_DEPTH; k++) begin
                  mask_ff[k] <= csr_data[8*k +: 8];
               end
            end
            mbee_pkg::CSR_MASK_COUNT: begin
               count_ff <= csr_data[3:0];
            end
            mbee_pkg::CSR_SECRET_LENGTH: begin
               secret_length_ff <= csr_data[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode          = mode_ff;
   assign cfg.bit_order     = bit_order_ff;
   assign cfg.secret_length = secret_length_ff;

   // Pipeline flow: the result register frees when empty or taken
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff   <= mbee_pkg::mbee_cmd_type'(req_tuser);
         in_data_ff  <= req_tdata[7:0];
         in_range_ff <= req_tdata[8];
      end
   end

   mbee_core u_core (
      .cfg       (cfg),
      .st        (state_ff),
      .mask      (mask_ff[pos_ff]),
      .command   (in_cmd_ff),
      .data_byte (in_data_ff),
      .in_range  (in_range_ff),
      .st_next   (state_in),
      .result    (result),
      .advance   (advance)
   );

   // Mask position: wrap at the clamped entry count
   assign count_eff = (count_ff == 4'd0)     ? 4'd1      :
                      (count_ff > DEPTH_CNT) ? DEPTH_CNT : count_ff;
   assign pos_plus  = 4'(pos_ff) + 4'd1;
   assign pos_in    = (pos_plus >= count_eff) ? '0 : POS_W'(pos_plus);

   // Block state: advance per item, clear buffer on a mode write
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         state_ff <= '0;
      end else begin
         if (csr_write && (csr_index == mbee_pkg::CSR_MODE)) begin
            state_ff.store <= '0;
            state_ff.fill  <= '0;
         end else if (step) begin
            state_ff <= state_in;
         end
         if (step && advance) begin
            pos_ff <= pos_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'b00000, rsp_ff.finished, rsp_ff.status, rsp_ff.data_out};

endmodule

// ===== rtl/mbee_checker.sv =====
// Port-level checks for masked_bit_embed_extract_top, attached by bind.
// Depends on mbee_pkg.
module mbee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [15:0] rsp_tdata
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // Finished stays set on a result item presented right after a taken finished one
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[10] |=> !rsp_tvalid || rsp_tdata[10])
      else $error("finished dropped");

   // Input stalls only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with free result register");

   // Underrun only on carrier items
   a_underrun_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9:8] == mbee_pkg::STATUS_UNDERRUN)
      |-> rsp_tuser == mbee_pkg::KIND_CARRIER)
      else $error("underrun on non-carrier item");

   // Accepted loads carry zero data and ok status
   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mbee_pkg::KIND_LOADED)
      |-> (rsp_tdata[7:0] == 8'h00) && (rsp_tdata[9:8] == mbee_pkg::STATUS_OK))
      else $error("load item with data or status");

endmodule

bind masked_bit_embed_extract_top mbee_checker u_mbee_checker (.*);
